// File: src/gpht_pkg.sv
// Package for the grid position hash table: widths, codes and shared types.
// Used by gpht_front, gpht_back and grid_position_hash_table_unit.
package gpht_pkg;

  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned SizeW = 11;
  localparam int unsigned KeyW = 32;
  localparam int unsigned KindW = 4;
  localparam int unsigned DataW = 32;
  localparam int unsigned IdxOutW = 10;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FOUND    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_READ, S_CHECK, S_CLEAR, S_OUT, S_INIT
  } bstate_e;

  typedef struct packed {
    op_e              op;
    logic [KeyW-1:0]  key;
    logic [KindW-1:0] kind;
    logic [DataW-1:0] data;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [IdxOutW-1:0] slot;
    logic [KindW-1:0]   kind;
    logic [DataW-1:0]   data;
  } res_t;

endpackage

// File: src/gpht_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module gpht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: src/gpht_front.sv
// Front end: accepts commands and queues them (two-entry FIFO).
// Depends on gpht_pkg.
module gpht_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  gpht_pkg::cmd_t      s_cmd_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output gpht_pkg::cmd_t      q_cmd_o
);
  import gpht_pkg::*;

  cmd_t       buf_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign s_ready_o = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o   = buf_q[rp_q];
  assign push = s_valid_i && s_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= s_cmd_i;
  end
endmodule

// File: src/gpht_back.sv
// Back end: modulo unit, probe sequencer, slot memories and result register.
// Depends on gpht_pkg and gpht_ram.
module gpht_back #(
  parameter int unsigned TableDepth = gpht_pkg::TableDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [gpht_pkg::SizeW-1:0]    size_i,
  input  logic                          q_valid_i,
  output logic                          q_ready_o,
  input  gpht_pkg::cmd_t                q_cmd_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output gpht_pkg::res_t                m_res_o
);
  import gpht_pkg::*;

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam int unsigned SW = (CW > SizeW) ? CW : SizeW;
  localparam int unsigned MCW = $clog2(KeyW + 1);

  bstate_e          st_q, st_d;
  cmd_t             cmd_q, cmd_d;
  logic [SW-1:0]    size_q, size_d;
  logic [SW:0]      rem_q, rem_d;
  logic [MCW-1:0]   mcnt_q, mcnt_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    n_q, n_d;
  res_t             res_q, res_d;
  res_t             out_q, out_d;
  logic             rvalid_q, rvalid_d;
  logic             used_we;
  logic             used_wdata;
  logic             used_rd;
  logic             mem_we;
  logic [KeyW-1:0]  rkey;
  logic [KindW-1:0] rkind;
  logic [DataW-1:0] rdata;
  logic [SW:0]      shl;
  logic [SW-1:0]    eff_size;
  logic [SW-1:0]    nxt_idx;

  always_comb begin
    eff_size = SW'(size_i);
    if (size_i == '0) eff_size = SW'(1);
    if (SW'(size_i) > SW'(TableDepth)) eff_size = SW'(TableDepth);
  end

  assign shl     = {rem_q[SW-1:0], cmd_q.key[KeyW-1-mcnt_q[MCW-1:0]]};
  assign nxt_idx = SW'(idx_q) + SW'(1);

  gpht_ram #(.Width(1), .Depth(TableDepth)) u_used (
    .clk_i, .we_i(used_we), .addr_i(idx_q), .wdata_i(used_wdata), .rdata_o(used_rd));
  gpht_ram #(.Width(KeyW), .Depth(TableDepth)) u_key (
    .clk_i, .we_i(mem_we), .addr_i(idx_q), .wdata_i(cmd_q.key), .rdata_o(rkey));
  gpht_ram #(.Width(KindW), .Depth(TableDepth)) u_kind (
    .clk_i, .we_i(mem_we), .addr_i(idx_q), .wdata_i(cmd_q.kind), .rdata_o(rkind));
  gpht_ram #(.Width(DataW), .Depth(TableDepth)) u_data (
    .clk_i, .we_i(mem_we), .addr_i(idx_q), .wdata_i(cmd_q.data), .rdata_o(rdata));

  assign q_ready_o = (st_q == S_IDLE);
  assign m_valid_o = rvalid_q;
  assign m_res_o   = out_q;

  always_comb begin
    st_d = st_q; cmd_d = cmd_q; size_d = size_q; rem_d = rem_q; mcnt_d = mcnt_q;
    idx_d = idx_q; n_d = n_q; res_d = res_q; rvalid_d = rvalid_q; out_d = out_q;
    mem_we = 1'b0; used_we = 1'b0; used_wdata = 1'b0;
    if (m_ready_i) rvalid_d = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (q_valid_i) begin
          cmd_d = q_cmd_i; size_d = eff_size; rem_d = '0; mcnt_d = '0;
          n_d = '0;
          res_d = '{status: ST_DONE, slot: '0, kind: '0, data: '0};
          case (q_cmd_i.op)
            OP_CLEAR: begin
              idx_d = '0; st_d = S_CLEAR;
            end
            OP_NONE: begin
              res_d.status = ST_NOTFOUND; st_d = S_OUT;
            end
            default: st_d = S_MOD;
          endcase
        end
      end
      // restoring division, one key bit a cycle
      S_MOD: begin
        rem_d = (shl >= {1'b0, size_q}) ? shl - {1'b0, size_q} : shl;
        mcnt_d = mcnt_q + MCW'(1);
        if (mcnt_q == MCW'(KeyW - 1)) begin
          idx_d = AW'(rem_d[SW-1:0]); st_d = S_READ;
        end
      end
      S_READ: st_d = S_CHECK;
      S_CHECK: begin
        st_d = S_OUT;
        if (!used_rd) begin
          if (cmd_q.op == OP_INSERT) begin
            mem_we = 1'b1; used_we = 1'b1; used_wdata = 1'b1;
            res_d.status = ST_DONE; res_d.slot = IdxOutW'(idx_q);
          end else begin
            res_d.status = ST_NOTFOUND;
          end
        end else if (cmd_q.op == OP_LOOKUP && rkey == cmd_q.key) begin
          res_d = '{status: ST_FOUND, slot: IdxOutW'(idx_q), kind: rkind, data: rdata};
        end else if (SW'(n_q) + SW'(1) >= size_q) begin
          res_d.status = (cmd_q.op == OP_INSERT) ? ST_FULL : ST_NOTFOUND;
        end else begin
          n_d = n_q + CW'(1);
          idx_d = (nxt_idx >= size_q) ? '0 : AW'(nxt_idx);
          st_d = S_READ;
        end
      end
      // drop every used bit, one slot a cycle
      S_CLEAR: begin
        used_we = 1'b1;
        if (idx_q == AW'(TableDepth - 1)) st_d = S_OUT;
        else idx_d = idx_q + AW'(1);
      end
      S_INIT: begin
        used_we = 1'b1;
        if (idx_q == AW'(TableDepth - 1)) st_d = S_IDLE;
        else idx_d = idx_q + AW'(1);
      end
      // hold the next result until the output register is free
      S_OUT: begin
        if (!rvalid_q || m_ready_i) begin
          out_d = res_q; rvalid_d = 1'b1; st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_INIT; rvalid_q <= 1'b0; idx_q <= '0;
    end else begin
      st_q <= st_d; rvalid_q <= rvalid_d; idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; size_q <= size_d; rem_q <= rem_d; mcnt_q <= mcnt_d;
    n_q <= n_d; res_q <= res_d; out_q <= out_d;
  end
endmodule

// File: src/grid_position_hash_table_unit.sv
// Grid position hash table, top level: front queue plus probing back end.
// Depends on gpht_pkg, gpht_front, gpht_back.
//
// Linear-probing hash table on key x | y<<16, home slot key mod table_size.
// One word at a time in the back end: insert and lookup take the word, run
// the bit-serial modulo, read and check each probed slot (registered slot
// memory read) and then issue the result; clear walks every slot first.
// After reset the same walk empties the table before the first word is taken.
// The result waits in an output register, so a stalled receiver only holds
// the back end once a second result is ready. A two-word queue in front lets
// the input side run ahead of the probe engine.
module grid_position_hash_table_unit #(
  parameter int unsigned TableDepth = gpht_pkg::TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // operation[1:0], pos_x[17:2], pos_y[33:18], entity_kind[37:34],
  // entity_data[69:38], zero pad
  input  logic [71:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[1:0], slot_index[11:2], found_kind[15:12], found_data[47:16]
  output logic [47:0] m_axis_tdata_o
);
  import gpht_pkg::*;

  logic [SizeW-1:0] size_q;
  cmd_t s_cmd, q_cmd;
  res_t res;
  logic q_valid, q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= SizeW'(1024);
    else if (cfg_we_i) size_q <= cfg_wdata_i;
  end

  assign s_cmd.op   = op_e'(s_axis_tdata_i[1:0]);
  assign s_cmd.key  = {s_axis_tdata_i[33:18], s_axis_tdata_i[17:2]};
  assign s_cmd.kind = s_axis_tdata_i[37:34];
  assign s_cmd.data = s_axis_tdata_i[69:38];

  gpht_front u_front (
    .clk_i, .rst_ni, .s_valid_i(s_axis_tvalid_i), .s_ready_o(s_axis_tready_o),
    .s_cmd_i(s_cmd), .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd));

  gpht_back #(.TableDepth(TableDepth)) u_back (
    .clk_i, .rst_ni, .size_i(size_q), .q_valid_i(q_valid), .q_ready_o(q_ready),
    .q_cmd_i(q_cmd), .m_valid_o(m_axis_tvalid_o), .m_ready_i(m_axis_tready_i),
    .m_res_o(res));

  assign m_axis_tdata_o = {res.data, res.kind, res.slot, res.status};
endmodule

// File: test/tb_grid_position_hash_table_unit.sv
// Testbench for grid_position_hash_table_unit: drives insert, lookup, clear and
// no-op words, predicts each result with a software copy of the table and compares.
// Depends on gpht_pkg and the RTL under src.
`timescale 1ns / 1ps

module tb_grid_position_hash_table_unit;
  import gpht_pkg::*;

  localparam int Depth = 1024;
  localparam int WatchLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;

  grid_position_hash_table_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // table copy
  bit          tbl_used [Depth];
  logic [31:0] tbl_key  [Depth];
  logic [3:0]  tbl_kind [Depth];
  logic [31:0] tbl_data [Depth];
  int unsigned tbl_size = 1024;

  res_t        pending_res[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;

  function automatic res_t probe_table(op_e op, logic [15:0] x, logic [15:0] y,
                                       logic [3:0] kind, logic [31:0] data);
    res_t r;
    int unsigned sz;
    logic [31:0] key;
    int unsigned slot;
    r = '{status: ST_NOTFOUND, slot: '0, kind: '0, data: '0};
    sz = (tbl_size == 0) ? 1 : (tbl_size > Depth ? Depth : tbl_size);
    key = {y, x};
    slot = key % sz;
    if (op == OP_CLEAR) begin
      foreach (tbl_used[i]) tbl_used[i] = 1'b0;
      r.status = ST_DONE;
      return r;
    end
    if (op == OP_NONE) return r;
    for (int n = 0; n < sz; n++) begin
      if (op == OP_INSERT) begin
        if (!tbl_used[slot]) begin
          tbl_used[slot] = 1'b1;
          tbl_key[slot] = key;
          tbl_kind[slot] = kind;
          tbl_data[slot] = data;
          r.status = ST_DONE;
          r.slot = slot[9:0];
          return r;
        end
      end else begin
        if (!tbl_used[slot]) return r;
        if (tbl_key[slot] == key) begin
          r.status = ST_FOUND;
          r.slot = slot[9:0];
          r.kind = tbl_kind[slot];
          r.data = tbl_data[slot];
          return r;
        end
      end
      slot = (slot + 1 >= sz) ? 0 : slot + 1;
    end
    if (op == OP_INSERT) r.status = ST_FULL;
    return r;
  endfunction

  task automatic send_word(op_e op, logic [15:0] x, logic [15:0] y,
                           logic [3:0] kind, logic [31:0] data);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    s_axis_tdata_i = {2'b00, data, kind, y, x, op};
    s_axis_tvalid_i = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_res.push_back(probe_table(op, x, y, kind, data));
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic drain_results();
    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic set_size(int unsigned sz);
    drain_results();
    cfg_wdata_i = sz[10:0];
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tbl_size = sz;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = '{status: status_e'(m_axis_tdata_o[1:0]), slot: m_axis_tdata_o[11:2],
                kind: m_axis_tdata_o[15:12], data: m_axis_tdata_o[47:16]};
        if (pending_res.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          errors++;
        end else begin
          want = pending_res.pop_front();
          if (got.status != want.status || got.slot != want.slot ||
              got.kind != want.kind || got.data != want.data) begin
            $display("%0t: expected status %0d slot %0d kind %0d data %h, got %0d %0d %0d %h",
                     $time, want.status, want.slot, want.kind, want.data,
                     got.status, got.slot, got.kind, got.data);
            errors++;
          end
        end
      end
    end
  end

  task automatic test_directed();
    send_word(OP_LOOKUP, 16'h0000, 16'h0000, 4'h1, 32'h0);
    send_word(OP_INSERT, 16'hFFFF, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 16'h0000, 16'h0000, 4'h0, 32'h0);
    send_word(OP_INSERT, 16'hFFFF, 16'hFFFF, 4'h1, 32'h1234_5678);
    send_word(OP_LOOKUP, 16'hFFFF, 16'hFFFF, 4'h0, 32'h0);
    send_word(OP_LOOKUP, 16'h0000, 16'h0000, 4'h0, 32'h0);
    send_word(OP_NONE,   16'hAAAA, 16'h5555, 4'hA, 32'hA5A5_A5A5);
    send_word(OP_LOOKUP, 16'h0400, 16'h0000, 4'h0, 32'h0);
    send_word(OP_CLEAR,  16'h0, 16'h0, 4'h0, 32'h0);
    send_word(OP_LOOKUP, 16'hFFFF, 16'hFFFF, 4'h0, 32'h0);
  endtask

  // tiny and odd sizes: full table, lookup with no empty slot
  task automatic test_small_sizes();
    set_size(0);
    send_word(OP_INSERT, 16'h0007, 16'h0001, 4'h3, 32'h33);
    send_word(OP_INSERT, 16'h0008, 16'h0001, 4'h4, 32'h44);
    send_word(OP_LOOKUP, 16'h0009, 16'h0000, 4'h0, 32'h0);
    send_word(OP_LOOKUP, 16'h0007, 16'h0001, 4'h0, 32'h0);
    set_size(3);
    for (int i = 0; i < 4; i++)
      send_word(OP_INSERT, 16'(i * 5), 16'h0, 4'(i + 1), 32'(i));
    send_word(OP_LOOKUP, 16'h0063, 16'h0, 4'h0, 32'h0);
    set_size(2047);
    send_word(OP_LOOKUP, 16'h0005, 16'h0, 4'h0, 32'h0);
    send_word(OP_CLEAR,  16'h0, 16'h0, 4'h0, 32'h0);
  endtask

  // keys from a small pool so lookups hit, chains grow and the table fills
  task automatic test_random(int count, int unsigned sz);
    logic [15:0] x, y;
    int unsigned r;
    set_size(sz);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 15) begin
        x = 16'($urandom); y = 16'($urandom);
      end else begin
        x = 16'($urandom_range(63)); y = 16'($urandom_range(3));
        if ($urandom_range(1)) y = ~y;
      end
      if (r < 45)
        send_word(OP_INSERT, x, y, 4'($urandom), $urandom);
      else if (r < 95)
        send_word(OP_LOOKUP, x, y, 4'($urandom), $urandom);
      else if (r < 97)
        send_word(OP_CLEAR, x, y, 4'($urandom), $urandom);
      else
        send_word(OP_NONE, x, y, 4'($urandom), $urandom);
      if (i == count / 2) drain_results();
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_small_sizes();
    test_random(450, 1024);
    send_idle_pct = 51;
    test_random(450, 7);
    send_idle_pct = 0; recv_stall_pct = 51;
    test_random(450, 64);
    send_idle_pct = 16; recv_stall_pct = 16;
    test_random(450, 1);
    drain_results();
    if (errors == 0 && pending_res.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
src/gpht_pkg.sv
src/gpht_ram.sv
src/gpht_front.sv
src/gpht_back.sv
src/grid_position_hash_table_unit.sv
test/tb_grid_position_hash_table_unit.sv
